[rtl/core/lmfs_pkg.sv]
// Shared types, constants and the color lookup for the LED matrix frame store.
`default_nettype none
package lmfs_pkg;

    localparam int WIDTH_DEF  = 11;
    localparam int HEIGHT_DEF = 11;
    localparam int FONT_W_DEF = 3;
    localparam int FONT_H_DEF = 5;

    localparam logic [23:0] COLOR_BLACK = 24'h000000;
    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [23:0] COLOR_GREEN = 24'h00FF00;

    typedef enum logic [1:0] {
        K_SET   = 2'd0,
        K_CLEAR = 2'd1,
        K_GLYPH = 2'd2,
        K_DRAW  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PT_OFF   = 3'd0,
        PT_TIME  = 3'd1,
        PT_NAME  = 3'd2,
        PT_ICON  = 3'd3,
        PT_OTHER = 3'd4
    } t_ptype;

    typedef enum logic [1:0] {
        REG_TIME_COLOR = 2'd0,
        REG_NAME_COLOR = 2'd1,
        REG_ICON_COLOR = 2'd2,
        REG_RAINBOW    = 2'd3
    } t_reg;

    function automatic logic [23:0] f_type_color(
        input logic [2:0]  ptype,
        input logic [23:0] time_color,
        input logic [23:0] name_color,
        input logic [23:0] icon_color,
        input logic        rainbow
    );
        logic [23:0] color;
        case (t_ptype'(ptype))
            PT_TIME:  color = rainbow ? COLOR_WHITE : time_color;
            PT_NAME:  color = rainbow ? COLOR_WHITE : name_color;
            PT_ICON:  color = rainbow ? COLOR_WHITE : icon_color;
            PT_OTHER: color = COLOR_GREEN;
            default:  color = COLOR_BLACK;
        endcase
        return color;
    endfunction

endpackage
`default_nettype wire

[rtl/core/lmfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lmfs_ram #(
    parameter int DATA_W = 3,
    parameter int DEPTH  = 121
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/led_matrix_frame_store.sv]
// Top level: pixel type store with set/clear/glyph writes and serpentine row readout.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | kind, coords, pixel_type, glyph, show
//  out     | output    | o_out_valid/i_out_ready | strip_index, pixel_color, last, show
//  cfg     | input     | APB psel/penable      | time/name/icon color, rainbow_mode
//
// Set pixel: one RAM write as the word is accepted. Glyph row: at most one RAM write per font column.
// Clear: one RAM entry per cycle, through all WIDTH*HEIGHT entries.
// Draw row: a RAM read then an output load per pixel, for HEIGHT pixels.
// Reset starts the same clearing pass; o_in_ready stays low meanwhile.
// A stalled output holds the draw sequence; new words wait until the block is idle.
`default_nettype none
module led_matrix_frame_store #(
    parameter int WIDTH  = lmfs_pkg::WIDTH_DEF,
    parameter int HEIGHT = lmfs_pkg::HEIGHT_DEF,
    parameter int FONT_W = lmfs_pkg::FONT_W_DEF,
    parameter int FONT_H = lmfs_pkg::FONT_H_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_first_coord,
    input  wire logic [7:0]  i_second_coord,
    input  wire logic [2:0]  i_pixel_type,
    input  wire logic [7:0]  i_glyph_bits,
    input  wire logic [3:0]  i_glyph_line,
    input  wire logic        i_show,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_strip_index,
    output logic [23:0]      o_pixel_color,
    output logic             o_last,
    output logic             o_show_strobe,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lmfs_pkg::*;

    localparam int DEPTH = WIDTH * HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(HEIGHT);
    localparam int JW    = (FONT_W > 1) ? $clog2(FONT_W) : 1;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_CLEAR    = 5'b00010,
        S_GLYPH    = 5'b00100,
        S_DRAW_RD  = 5'b01000,
        S_DRAW_OUT = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_row;
    logic [7:0]  r_second;
    logic [2:0]  r_ptype;
    logic [7:0]  r_bits;
    logic        r_show;
    logic [CW-1:0] r_col;
    logic [JW-1:0] r_j;
    logic [AW-1:0] r_clr;

    logic [23:0] r_time_color, r_name_color, r_icon_color;
    logic        r_rainbow;

    logic        r_out_valid;
    logic [7:0]  r_strip_index;
    logic [23:0] r_pixel_color;
    logic        r_last;
    logic        r_show_strobe;

    logic        w_in_acc;
    logic        w_cfg_wr;
    logic        w_we;
    logic [7:0]  w_wa, w_wb;
    logic [2:0]  w_wt;
    logic [15:0] w_waddr_full;
    logic [AW-1:0] w_waddr;
    logic [15:0] w_raddr_full;
    logic [2:0]  w_rdata;
    logic        w_out_load;
    logic        w_col_last;
    logic [CW-1:0] w_pos;
    logic [15:0] w_strip_full;
    logic [7:0]  w_glyph_row;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_glyph_row = 8'(i_glyph_line) + i_first_coord;

    // write port select
    always_comb begin
        w_we = 1'b0;
        w_wa = i_first_coord;
        w_wb = i_second_coord;
        w_wt = i_pixel_type;
        case (r_state)
            S_IDLE: begin
                w_we = w_in_acc && (t_kind'(i_kind) == K_SET);
            end
            S_GLYPH: begin
                w_wa = r_row;
                w_wb = 8'(FONT_W - 1) - 8'(r_j) + r_second;
                w_wt = r_ptype;
                w_we = r_bits[0];
            end
            S_CLEAR: begin
                w_we = 1'b1;
                w_wt = PT_OFF;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        if (r_state != S_CLEAR) begin
            w_we = w_we && (w_wa < 8'(WIDTH)) && (w_wb < 8'(HEIGHT));
        end
    end

    assign w_waddr_full = 16'(w_wa) * 16'(HEIGHT) + 16'(w_wb);
    assign w_waddr      = (r_state == S_CLEAR) ? r_clr : w_waddr_full[AW-1:0];
    assign w_raddr_full = 16'(r_row) * 16'(HEIGHT) + 16'(r_col);

    lmfs_ram #(
        .DATA_W (3),
        .DEPTH  (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wt),
        .i_re    (r_state == S_DRAW_RD),
        .i_raddr (w_raddr_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_out_load   = (r_state == S_DRAW_OUT) && (!r_out_valid || i_out_ready);
    assign w_col_last   = (r_col == CW'(HEIGHT - 1));
    assign w_pos        = r_row[0] ? (CW'(HEIGHT - 1) - r_col) : r_col;
    assign w_strip_full = 16'(r_row) * 16'(HEIGHT) + 16'(w_pos);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (t_kind'(i_kind))
                        K_CLEAR: n_state = S_CLEAR;
                        K_GLYPH: begin
                            if (5'(i_glyph_line) < 5'(FONT_H)) begin
                                n_state = S_GLYPH;
                            end
                        end
                        K_DRAW: begin
                            if (i_first_coord < 8'(WIDTH)) begin
                                n_state = S_DRAW_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_GLYPH: begin
                if (r_j == JW'(FONT_W - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW_RD: n_state = S_DRAW_OUT;
            S_DRAW_OUT: begin
                if (w_out_load) begin
                    n_state = w_col_last ? S_IDLE : S_DRAW_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= (r_clr == AW'(DEPTH - 1)) ? '0 : r_clr + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_row    <= (t_kind'(i_kind) == K_GLYPH) ? w_glyph_row : i_first_coord;
            r_second <= i_second_coord;
            r_ptype  <= i_pixel_type;
            r_bits   <= i_glyph_bits;
            r_show   <= i_show;
            r_col    <= '0;
            r_j      <= '0;
        end else begin
            if (r_state == S_GLYPH) begin
                r_bits <= r_bits >> 1;
                r_j    <= r_j + 1'b1;
            end
            if (w_out_load) begin
                r_col <= r_col + 1'b1;
            end
        end
        if (w_out_load) begin
            r_strip_index <= w_strip_full[7:0];
            r_pixel_color <= f_type_color(w_rdata, r_time_color, r_name_color,
                                          r_icon_color, r_rainbow);
            r_last        <= w_col_last;
            r_show_strobe <= w_col_last && r_show;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_strip_index = r_strip_index;
    assign o_pixel_color = r_pixel_color;
    assign o_last        = r_last;
    assign o_show_strobe = r_show_strobe;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_color <= COLOR_WHITE;
            r_name_color <= COLOR_WHITE;
            r_icon_color <= COLOR_WHITE;
            r_rainbow    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (t_reg'(paddr[3:2]))
                REG_TIME_COLOR: r_time_color <= pwdata[23:0];
                REG_NAME_COLOR: r_name_color <= pwdata[23:0];
                REG_ICON_COLOR: r_icon_color <= pwdata[23:0];
                REG_RAINBOW:    r_rainbow    <= pwdata[0];
                default:        r_rainbow    <= r_rainbow;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_TIME_COLOR: prdata = {8'd0, r_time_color};
            REG_NAME_COLOR: prdata = {8'd0, r_name_color};
            REG_ICON_COLOR: prdata = {8'd0, r_icon_color};
            REG_RAINBOW:    prdata = {31'd0, r_rainbow};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/lmfs_checker.sv]
// Port-level checks for the LED matrix frame store, bound to the top level.
`default_nettype none
module lmfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_kind,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_strip_index,
    input wire logic [23:0] o_pixel_color,
    input wire logic        o_last,
    input wire logic        o_show_strobe
);
    import lmfs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_strip_index) && $stable(o_pixel_color)
            && $stable(o_last) && $stable(o_show_strobe))
        else $error("stalled output word changed");

    a_strobe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_show_strobe |-> o_last)
        else $error("show strobe without last");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("reset did not start clearing pass");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == K_CLEAR) |=> !o_in_ready)
        else $error("clear word did not block input");

endmodule

bind led_matrix_frame_store lmfs_checker u_lmfs_checker (.*);
`default_nettype wire

[sim/tb_led_matrix_frame_store.sv]
// Testbench for led_matrix_frame_store: directed and random words checked against a local model.
`timescale 1ns / 1ps
module testbench;
    import lmfs_pkg::*;

    localparam int WIDTH         = WIDTH_DEF;
    localparam int HEIGHT        = HEIGHT_DEF;
    localparam int FONT_W        = FONT_W_DEF;
    localparam int FONT_H        = FONT_H_DEF;
    localparam int SETTLE_CYCLES = 2 * WIDTH * HEIGHT + 40;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [2:0] PT_UNUSED_5 = 3'd5;
    localparam logic [2:0] PT_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [7:0]  strip_index;
        logic [23:0] pixel_color;
        logic        last;
        logic        show_strobe;
    } t_pixel_out;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind_q = '0;
    logic [7:0]  first_q = '0;
    logic [7:0]  second_q = '0;
    logic [2:0]  ptype_q = '0;
    logic [7:0]  bits_q = '0;
    logic [3:0]  line_q = '0;
    logic        show_q = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  strip_index;
    logic [23:0] pixel_color;
    logic        last;
    logic        show_strobe;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [2:0]  type_mem [WIDTH*HEIGHT];
    logic [23:0] time_rgb = COLOR_WHITE;
    logic [23:0] name_rgb = COLOR_WHITE;
    logic [23:0] icon_rgb = COLOR_WHITE;
    logic        rainbow = 1'b0;

    t_pixel_out  pending_pixels [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;

    led_matrix_frame_store u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind_q),
        .i_first_coord  (first_q),
        .i_second_coord (second_q),
        .i_pixel_type   (ptype_q),
        .i_glyph_bits   (bits_q),
        .i_glyph_line   (line_q),
        .i_show         (show_q),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_strip_index  (strip_index),
        .o_pixel_color  (pixel_color),
        .o_last         (last),
        .o_show_strobe  (show_strobe),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("led_matrix_frame_store test failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_field(input string field, input logic [23:0] exp_v,
                                input logic [23:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        t_pixel_out exp_px;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual index %h color %h",
                         $time, strip_index, pixel_color);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                report_field("strip_index", 24'(exp_px.strip_index), 24'(strip_index));
                report_field("pixel_color", exp_px.pixel_color, pixel_color);
                report_field("last", 24'(exp_px.last), 24'(last));
                report_field("show_strobe", 24'(exp_px.show_strobe), 24'(show_strobe));
            end
        end
    end

    function automatic logic [23:0] pixel_rgb(input logic [2:0] t);
        logic [23:0] rgb;
        case (t)
            PT_TIME:  rgb = time_rgb;
            PT_NAME:  rgb = name_rgb;
            PT_ICON:  rgb = icon_rgb;
            PT_OTHER: return COLOR_GREEN;
            default:  return COLOR_BLACK;
        endcase
        return rainbow ? COLOR_WHITE : rgb;
    endfunction

    function automatic void store_type(input logic [7:0] a, input logic [7:0] b,
                                       input logic [2:0] t);
        if (a < WIDTH && b < HEIGHT)
            type_mem[a*HEIGHT + b] = t;
    endfunction

    task automatic apply_word(input t_kind kind, input logic [7:0] first,
                              input logic [7:0] second, input logic [2:0] ptype,
                              input logic [7:0] bits, input logic [3:0] line,
                              input logic show);
        logic [7:0] row;
        logic [7:0] col;
        int         pos;
        t_pixel_out px;
        case (kind)
            K_SET: store_type(first, second, ptype);
            K_CLEAR: foreach (type_mem[k]) type_mem[k] = PT_OFF;
            K_GLYPH: begin
                if (line < FONT_H) begin
                    for (int j = 0; j < FONT_W && j < 8; j++) begin
                        if (bits[j]) begin
                            row = 8'(line) + first;
                            col = 8'(FONT_W - 1 - j) + second;
                            store_type(row, col, ptype);
                        end
                    end
                end
            end
            K_DRAW: begin
                if (first < WIDTH) begin
                    for (int c = 0; c < HEIGHT; c++) begin
                        pos = first[0] ? HEIGHT - 1 - c : c;
                        px.strip_index = 8'(first * HEIGHT + pos);
                        px.pixel_color = pixel_rgb(type_mem[first*HEIGHT + c]);
                        px.last        = (c == HEIGHT - 1);
                        px.show_strobe = px.last & show;
                        pending_pixels.push_back(px);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_kind kind, input logic [7:0] first,
                             input logic [7:0] second, input logic [2:0] ptype,
                             input logic [7:0] bits, input logic [3:0] line,
                             input logic show);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind_q   <= kind;
        first_q  <= first;
        second_q <= second;
        ptype_q  <= ptype;
        bits_q   <= bits;
        line_q   <= line;
        show_q   <= show;
        do @(posedge clk); while (!in_ready);
        apply_word(kind, first, second, ptype, bits, line, show);
    endtask

    task automatic set_px(input logic [7:0] first, input logic [7:0] second,
                          input logic [2:0] ptype);
        send_word(K_SET, first, second, ptype, 8'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic glyph_row(input logic [7:0] top, input logic [7:0] left,
                             input logic [3:0] line, input logic [7:0] bits,
                             input logic [2:0] ptype);
        send_word(K_GLYPH, top, left, ptype, bits, line, 1'($urandom));
    endtask

    task automatic draw_row(input logic [7:0] row, input logic show);
        send_word(K_DRAW, row, 8'($urandom), 3'($urandom), 8'($urandom), 4'($urandom), show);
    endtask

    task automatic clear_all();
        send_word(K_CLEAR, 8'($urandom), 8'($urandom), 3'($urandom), 8'($urandom),
                  4'($urandom), 1'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TIME_COLOR: time_rgb = value[23:0];
            REG_NAME_COLOR: name_rgb = value[23:0];
            REG_ICON_COLOR: icon_rgb = value[23:0];
            REG_RAINBOW:    rainbow  = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_rgb();
        logic [23:0] rgb;
        case ($urandom_range(0, 3))
            0:       rgb = COLOR_BLACK;
            1:       rgb = COLOR_WHITE;
            default: rgb = 24'($urandom);
        endcase
        return {8'($urandom), rgb};
    endfunction

    task automatic randomize_colors();
        cfg_write(REG_TIME_COLOR, pick_rgb());
        cfg_write(REG_NAME_COLOR, pick_rgb());
        cfg_write(REG_ICON_COLOR, pick_rgb());
        cfg_write(REG_RAINBOW, {$urandom} & 32'hFFFF_FFFE | 32'($urandom_range(0, 2) == 0));
    endtask

    task automatic test_reset_state();
        draw_row(8'd0, 1'b1);
        draw_row(8'(WIDTH - 1), 1'b0);
        draw_row(8'(WIDTH), 1'b1);
    endtask

    task automatic test_single_pixels();
        drain_results();
        cfg_write(REG_TIME_COLOR, 32'hA500_0000);
        cfg_write(REG_NAME_COLOR, 32'h5AFF_FFFF);
        cfg_write(REG_ICON_COLOR, {8'($urandom), 24'h12_34_56});
        cfg_write(REG_RAINBOW, 32'hFFFF_FFFE);
        set_px(8'd0, 8'd0, PT_TIME);
        set_px(8'd0, 8'(HEIGHT - 1), PT_NAME);
        set_px(8'(WIDTH - 1), 8'd0, PT_ICON);
        set_px(8'(WIDTH - 1), 8'(HEIGHT - 1), PT_OTHER);
        set_px(8'd1, 8'd5, PT_UNUSED_5);
        set_px(8'd1, 8'd6, PT_UNUSED_7);
        set_px(8'(WIDTH), 8'd0, PT_TIME);
        set_px(8'd0, 8'(HEIGHT), PT_TIME);
        set_px(8'hFF, 8'hFF, PT_OTHER);
        draw_row(8'd0, 1'b0);
        draw_row(8'd1, 1'b1);
        draw_row(8'(WIDTH - 1), 1'b1);
    endtask

    task automatic test_glyph_rows();
        glyph_row(8'd2, 8'd3, 4'd0, 8'hFF, PT_NAME);
        glyph_row(8'd254, 8'd4, 4'd3, 8'b101, PT_ICON);
        glyph_row(8'd4, 8'd254, 4'd1, 8'b111, PT_TIME);
        glyph_row(8'd0, 8'd0, 4'(FONT_H), 8'hFF, PT_OTHER);
        glyph_row(8'd0, 8'd0, 4'hF, 8'hFF, PT_OTHER);
        draw_row(8'd1, 1'b0);
        draw_row(8'd2, 1'b1);
        draw_row(8'd5, 1'b0);
    endtask

    task automatic test_clear_and_rainbow();
        drain_results();
        cfg_write(REG_RAINBOW, 32'h0000_0001);
        draw_row(8'd0, 1'b1);
        clear_all();
        draw_row(8'd0, 1'b1);
    endtask

    function automatic logic [7:0] pick_coord(input int span);
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return 8'($urandom_range(250, 255));
            default: return 8'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic test_random_traffic(input int count);
        int          r;
        logic [2:0]  ptype;
        logic [3:0]  line;
        drain_results();
        randomize_colors();
        repeat (count) begin
            r     = $urandom_range(0, 99);
            ptype = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            line  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, FONT_H - 1));
            if (r < 5)
                clear_all();
            else if (r < 40)
                set_px(pick_coord(WIDTH), pick_coord(HEIGHT), ptype);
            else if (r < 65)
                glyph_row(pick_coord(WIDTH), pick_coord(HEIGHT), line, 8'($urandom), ptype);
            else
                draw_row(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, WIDTH - 1)),
                         1'($urandom));
        end
    endtask

    initial begin
        foreach (type_mem[k]) type_mem[k] = PT_OFF;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!in_ready);
        test_reset_state();
        test_single_pixels();
        test_glyph_rows();
        test_clear_and_rainbow();
        repeat (4) test_random_traffic(22);
        drain_results();
        idle_on = 1'b0;
        test_random_traffic(20);
        drain_results();
        if (error_count == 0)
            $display("led_matrix_frame_store test passed");
        else
            $display("led_matrix_frame_store test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lmfs_pkg.sv
rtl/core/lmfs_ram.sv
rtl/core/led_matrix_frame_store.sv
rtl/core/lmfs_checker.sv
sim/tb_led_matrix_frame_store.sv
